@@ hw/rtl/icy_pkg.sv @@
package icy_pkg;

    localparam int CHUNK      = 8192;
    localparam int CHUNK_W    = $clog2(CHUNK);
    localparam int INTERVAL_W = 24;
    localparam int META_W     = 12;

    localparam logic KIND_AUDIO = 1'b0;
    localparam logic KIND_META  = 1'b1;

    typedef logic [CHUNK_W-1:0]    chunk_pos_t;
    typedef logic [INTERVAL_W-1:0] interval_t;
    typedef logic [META_W-1:0]     meta_cnt_t;

    typedef enum logic [1:0] {
        PH_AUDIO  = 2'd0,
        PH_LENGTH = 2'd1,
        PH_META   = 2'd2
    } phase_t;

    typedef struct packed {
        logic emit;
        logic kind;
        logic last;
    } icy_result_t;

endpackage

@@ hw/rtl/icy_parser.sv @@
module icy_parser
    import icy_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data,
    input  interval_t   interval,
    output icy_result_t res
);

    phase_t     phase_reg, phase_next;
    interval_t  audio_pos_reg, audio_pos_next;
    chunk_pos_t chunk_pos_reg, chunk_pos_next;
    meta_cnt_t  meta_rem_reg, meta_rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_AUDIO;
            audio_pos_reg <= '0;
            chunk_pos_reg <= '0;
            meta_rem_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            audio_pos_reg <= audio_pos_next;
            chunk_pos_reg <= chunk_pos_next;
            meta_rem_reg  <= meta_rem_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        audio_pos_next = audio_pos_reg;
        chunk_pos_next = chunk_pos_reg;
        meta_rem_next  = meta_rem_reg;
        res.emit       = 1'b1;
        res.kind       = KIND_AUDIO;
        res.last       = 1'b0;

        unique case (phase_reg)
            PH_LENGTH:
            begin
                // length code: L * 16 metadata bytes follow, no beat
                res.emit      = 1'b0;
                meta_rem_next = {data, 4'b0000};
                phase_next    = (data == 8'd0) ? PH_AUDIO : PH_META;
            end
            PH_META:
            begin
                res.kind = KIND_META;
                res.last = (meta_rem_reg <= meta_cnt_t'(1));
                if (res.last)
                begin
                    meta_rem_next = '0;
                    phase_next    = PH_AUDIO;
                end
                else
                begin
                    meta_rem_next = meta_rem_reg - meta_cnt_t'(1);
                end
            end
            default:
            begin
                phase_next = PH_AUDIO;
                res.last   = (chunk_pos_reg >= chunk_pos_t'(CHUNK - 1));
                if (interval == '0)
                begin
                    audio_pos_next = '0;
                end
                else if (({1'b0, audio_pos_reg} + 25'd1) >= {1'b0, interval})
                begin
                    res.last       = 1'b1;
                    audio_pos_next = '0;
                    phase_next     = PH_LENGTH;
                end
                else
                begin
                    audio_pos_next = audio_pos_reg + interval_t'(1);
                end
                chunk_pos_next = res.last ? '0 : chunk_pos_reg + chunk_pos_t'(1);
            end
        endcase
    end

endmodule

@@ hw/rtl/icy_metadata_stream_demux_top.sv @@
// Output is registered; an accepted input beat appears in the next cycle.
// Throughput: 1 byte per cycle unless the output stalls; the metadata
//   length code byte is consumed without an output beat.
// Reset: asynchronous, active low; clears the interval to zero, returns to
//   the audio phase with all counters at zero and the output empty.
module icy_metadata_stream_demux_top
    import icy_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  interval_t  cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] stream_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_kind,
    output logic       message_last
);

    interval_t   interval_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        kind_reg;
    logic        last_reg;
    logic        accept;
    icy_result_t res;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            interval_reg <= cfg_wr_data;
        end
    end

    icy_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .data     (stream_byte),
        .interval (interval_reg),
        .res      (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = res.emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res.emit)
        begin
            out_byte_reg <= stream_byte;
            kind_reg     <= res.kind;
            last_reg     <= res.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign byte_kind    = kind_reg;
    assign message_last = last_reg;

endmodule

@@ hw/rtl/icy_checker.sv @@
module icy_checker
    import icy_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_kind,
    input logic       message_last
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(byte_kind) && $stable(message_last))
        else $error("stalled output beat changed");

    // input side only blocks on a stalled output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without output stall");

    // a new output beat needs an accepted input beat
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("output beat without input beat");

    // taken output with no new input drains
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
        else $error("output beat repeated");

endmodule

bind icy_metadata_stream_demux_top icy_checker u_icy_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_kind    (byte_kind),
    .message_last (message_last)
);
